>>> rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// shared constants, codes and types for the table linear interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CFG_W       = 5;
	localparam int DATA_W      = 32;
	localparam int ENTRY_W     = 2 * DATA_W;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REGION_INTERP = 2'd0;
	localparam logic [1:0] REGION_FIRST  = 2'd1;
	localparam logic [1:0] REGION_LAST   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tli_div.sv
// ----------------------------------------------------------------------------
// tli_div
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle; the quotient must fit in 32 bits
// ----------------------------------------------------------------------------
module tli_div
	import tli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0]   divisor,
	output logic                done,
	output logic [DATA_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(DATA_W);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] div_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;
	logic              fits;

	always_comb begin
		shifted = {rem_q, lo_q[DATA_W-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		fits    = ~diff[DATA_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high half is already below the divisor, so only the low half is shifted in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*DATA_W-1:DATA_W];
			lo_q  <= dividend[DATA_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			lo_q  <= {lo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = lo_q;

endmodule

>>> rtl/table_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_top
// breakpoint table in ram with a linear search and interpolation per query
// ----------------------------------------------------------------------------
// load: accepted in idle and written to the ram, no result. query: the search
// reads table entries in order (1 to points_in_use, where 0 counts as 1 and
// values above 16 as 16), then the result state when clamped, or a multiply,
// a 32-step division and the result state when interpolated; the result state
// waits for the output to be free, and queries are taken one at a time.
// reset clears control and sets points_in_use to 1; table undefined until loaded.
module table_linear_interpolator_top
	import tli_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_W-1:0]         cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] x_value,
	input  logic signed [DATA_W-1:0] y_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] y_out,
	output logic [1:0]               region
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]  points_in_use_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  n_sat;
	logic [IDX_W-1:0]  i_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] prev_x_q;
	logic [DATA_W-1:0] prev_y_q;
	logic [DATA_W-1:0] dx_q;
	logic [DATA_W-1:0] span_q;
	logic [DATA_W-1:0] mag_q;
	logic              neg_q;
	logic [DATA_W-1:0] y0_q;
	logic [2*DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] res_y_q;
	logic [1:0]        res_region_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_y_q;
	logic [1:0]        out_region_q;

	logic              in_xfer;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [DATA_W-1:0] rd_x;
	logic [DATA_W-1:0] rd_y;
	logic              below;
	logic              last_entry;
	logic              out_free;
	logic [DATA_W:0]   dy;
	logic [DATA_W:0]   dy_abs;
	logic [DATA_W-1:0] quotient;
	logic              div_start;
	logic              div_done;

	assign in_xfer  = in_valid && in_ready;
	assign ram_we   = in_xfer && (op == OP_LOAD);
	assign rd_x     = ram_rdata[ENTRY_W-1:DATA_W];
	assign rd_y     = ram_rdata[DATA_W-1:0];
	assign below    = $signed(x_q) > $signed(rd_x);
	assign last_entry = ({1'b0, i_q} + CNT_W'(1)) == n_q;
	assign out_free = !out_valid_q || out_ready;

	// the next entry is fetched while the current one is compared
	assign ram_raddr = (state_q == ST_SEARCH) ? i_q + 1'b1 : '0;

	always_comb begin
		if (points_in_use_q == '0) begin
			n_sat = CNT_W'(1);
		end else if (int'(points_in_use_q) > TABLE_DEPTH) begin
			n_sat = CNT_W'(TABLE_DEPTH);
		end else begin
			n_sat = CNT_W'(points_in_use_q);
		end
	end

	always_comb begin
		dy     = {rd_y[DATA_W-1], rd_y} - {prev_y_q[DATA_W-1], prev_y_q};
		dy_abs = dy[DATA_W] ? -dy : dy;
	end

	tli_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(entry_index),
		.wdata({x_value, y_value}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q),
		.divisor (span_q),
		.done    (div_done),
		.quotient(quotient)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (op == OP_QUERY)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!below) begin
					state_d = (i_q == '0) ? ST_RESULT : ST_MUL;
				end else if (last_entry) begin
					state_d = ST_RESULT;
				end
			end
			ST_MUL:       state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the fsm
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:      in_ready = 1'b1;
			ST_DIV_START: div_start = 1'b1;
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			points_in_use_q <= CFG_W'(1);
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				points_in_use_q <= cfg_wr_data;
			end
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= x_value;
			n_q <= n_sat;
			i_q <= '0;
		end
		case (state_q)
			ST_SEARCH: begin
				prev_x_q <= rd_x;
				prev_y_q <= rd_y;
				i_q      <= i_q + 1'b1;
				if (!below) begin
					res_y_q      <= rd_y;
					res_region_q <= (i_q == '0) ? REGION_FIRST : REGION_INTERP;
					dx_q         <= x_q - prev_x_q;
					span_q       <= rd_x - prev_x_q;
					mag_q        <= dy_abs[DATA_W-1:0];
					neg_q        <= dy[DATA_W];
					y0_q         <= prev_y_q;
				end else if (last_entry) begin
					res_y_q      <= rd_y;
					res_region_q <= REGION_LAST;
				end
			end
			ST_MUL: prod_q <= dx_q * mag_q;
			ST_DIV: begin
				if (div_done) begin
					res_y_q <= neg_q ? y0_q - quotient : y0_q + quotient;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					out_y_q      <= res_y_q;
					out_region_q <= res_region_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign y_out     = out_y_q;
	assign region    = out_region_q;

endmodule
